/* design/iir_direct_form_2_transposed_defines.svh */
// ----------------------------------------------------------------------------
// iir_direct_form_2_transposed_defines
// assertion macros shared by the filter modules
// ----------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_2_TRANSPOSED_DEFINES_SVH
`define IIR_DIRECT_FORM_2_TRANSPOSED_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define IIR_DF2T_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define IIR_DF2T_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/iir_df2t_pkg.sv */
// ----------------------------------------------------------------------------
// iir_df2t_pkg
// widths, register indexes, control types and saturation helpers of the filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iir_df2t_pkg;

    localparam int COEF_BITS    = 32;
    localparam int OPND_BITS    = 32;
    localparam int DELAY_BITS   = 56;
    localparam int PROD_BITS    = COEF_BITS + OPND_BITS;
    localparam int SUM_BITS     = DELAY_BITS + 1;
    localparam int ORDER_BITS   = 2;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORDER = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM0  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEN1  = 3'd5;

    localparam logic signed [DELAY_BITS-1:0] DELAY_MAX = {1'b0, {(DELAY_BITS-1){1'b1}}};
    localparam logic signed [DELAY_BITS-1:0] DELAY_MIN = {1'b1, {(DELAY_BITS-1){1'b0}}};

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic use_base;
        logic subtract;
    } mac_ctrl_t;

    function automatic logic signed [DELAY_BITS-1:0] sat_prod(
        input logic signed [PROD_BITS-1:0] v
    );
        logic [PROD_BITS-DELAY_BITS:0] hi;
        hi = v[PROD_BITS-1:DELAY_BITS-1];
        if (hi == '0 || hi == '1) begin
            return v[DELAY_BITS-1:0];
        end else if (v[PROD_BITS-1]) begin
            return DELAY_MIN;
        end else begin
            return DELAY_MAX;
        end
    endfunction

    function automatic logic signed [DELAY_BITS-1:0] sat_sum(
        input logic signed [SUM_BITS-1:0] v
    );
        if (v[SUM_BITS-1] == v[SUM_BITS-2]) begin
            return v[DELAY_BITS-1:0];
        end else if (v[SUM_BITS-1]) begin
            return DELAY_MIN;
        end else begin
            return DELAY_MAX;
        end
    endfunction

endpackage

`default_nettype wire

/* design/iir_direct_form_2_transposed.sv */
// ----------------------------------------------------------------------------
// iir_direct_form_2_transposed
// direct form II transposed iir filter, order 1 to 3, q4.28 coefficients
//
//   channel  dir  handshake         payload
//   s_       in   s_valid/s_ready   s_sample_in, s_block_end
//   m_       out  m_valid/m_ready   m_filtered_out, m_block_end_out, m_clipped
//   cfg_     in   cfg_we            cfg_index, cfg_wdata
//
// result offered when the sequencer returns to idle, s_ready with it
// one shared multiplier and accumulator walks b0, then b_k and a_k per stage
// s_ready is high only while the sequencer is idle
// a stalled result in the output register holds the sequencer until the beat is taken
// reset clears the delay line and loads the default coefficients
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "iir_direct_form_2_transposed_defines.svh"

module iir_direct_form_2_transposed import iir_df2t_pkg::*; #(
    parameter int MAX_ORDER      = 3,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  wire logic [COEF_BITS-1:0]           cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]  s_sample_in,
    input  wire logic                           s_block_end,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_filtered_out,
    output logic                                m_block_end_out,
    output logic                                m_clipped
);

    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        COEF_BITS'(64'sd1 <<< COEF_FRAC_BITS);
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX =
        SAMPLE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = ~OUT_MAX;

    logic [ORDER_BITS-1:0]          order_reg;
    logic signed [COEF_BITS-1:0]    num_reg [MAX_ORDER+1];
    logic signed [COEF_BITS-1:0]    den_reg [MAX_ORDER];
    logic                           m_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  filtered_reg;
    logic                           be_out_reg;
    logic                           clip_out_reg;

    logic                           seq_idle;
    logic                           seq_done;
    logic signed [SAMPLE_BITS-1:0]  seq_y;
    logic                           seq_clip;
    logic                           seq_be;
    logic                           out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_BITS'(1);
            num_reg[0] <= COEF_ONE;
            for (int k = 1; k <= MAX_ORDER; k++) begin
                num_reg[k] <= '0;
            end
            for (int k = 0; k < MAX_ORDER; k++) begin
                den_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index == REG_ORDER) begin
                order_reg <= cfg_wdata[ORDER_BITS-1:0];
            end
            for (int k = 0; k <= MAX_ORDER; k++) begin
                if (cfg_index == CFG_IDX_BITS'(REG_NUM0 + k)) begin
                    num_reg[k] <= cfg_wdata;
                end
            end
            for (int k = 0; k < MAX_ORDER; k++) begin
                if (cfg_index == CFG_IDX_BITS'(REG_DEN1 + k)) begin
                    den_reg[k] <= cfg_wdata;
                end
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = seq_idle;

    iir_df2t_seq #(
        .MAX_ORDER      (MAX_ORDER),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (s_valid && seq_idle),
        .sample        (s_sample_in),
        .block_end     (s_block_end),
        .filter_order  (order_reg),
        .num_coef      (num_reg),
        .den_coef      (den_reg),
        .out_free      (out_free),
        .idle          (seq_idle),
        .done          (seq_done),
        .y_out         (seq_y),
        .clip_out      (seq_clip),
        .block_end_out (seq_be)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_done) begin
            filtered_reg <= seq_y;
            be_out_reg   <= seq_be;
            clip_out_reg <= seq_clip;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_filtered_out  = filtered_reg;
    assign m_block_end_out = be_out_reg;
    assign m_clipped       = clip_out_reg;

    `IIR_DF2T_ASSERT_NXT(a_busy_after_accept, (s_valid && s_ready), (!s_ready),
        "input accepted twice without processing")
    `IIR_DF2T_ASSERT_IMP(a_clip_at_limit, (m_valid && m_clipped),
        (m_filtered_out == OUT_MAX || m_filtered_out == OUT_MIN),
        "clipped beat not at a saturation limit")
    `IIR_DF2T_ASSERT_NXT(a_out_hold, (m_valid && !m_ready),
        (m_valid && $stable(m_filtered_out) && $stable(m_clipped)),
        "stalled result beat changed before it was taken")

endmodule

`default_nettype wire

/* design/iir_df2t_mac.sv */
// ----------------------------------------------------------------------------
// iir_df2t_mac
// shared multiplier with registered product and saturating 56-bit accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iir_df2t_mac import iir_df2t_pkg::*; (
    input  wire logic                          aclk,
    input  wire mac_ctrl_t                     ctrl,
    input  wire logic signed [COEF_BITS-1:0]   coef,
    input  wire logic signed [OPND_BITS-1:0]   opnd,
    input  wire logic signed [DELAY_BITS-1:0]  base,
    output logic signed [DELAY_BITS-1:0]       sum,
    output logic signed [DELAY_BITS-1:0]       acc
);

    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [DELAY_BITS-1:0] acc_reg;
    logic signed [DELAY_BITS-1:0] prod_sat;
    logic signed [DELAY_BITS-1:0] src;
    logic signed [SUM_BITS-1:0]   sum_wide;

    always_comb begin
        prod_sat = sat_prod(prod_reg);
        src      = ctrl.use_base ? base : acc_reg;
        if (ctrl.subtract) begin
            sum_wide = SUM_BITS'(src) - SUM_BITS'(prod_sat);
        end else begin
            sum_wide = SUM_BITS'(src) + SUM_BITS'(prod_sat);
        end
        sum = sat_sum(sum_wide);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= coef * opnd;
        end
        if (ctrl.acc_en) begin
            acc_reg <= sum;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

/* design/iir_df2t_seq.sv */
// ----------------------------------------------------------------------------
// iir_df2t_seq
// sequencer: walks the filter stages through the shared mac, keeps delay line
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "iir_direct_form_2_transposed_defines.svh"

module iir_df2t_seq import iir_df2t_pkg::*; #(
    parameter int MAX_ORDER      = 3,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic signed [SAMPLE_BITS-1:0]  sample,
    input  wire logic                           block_end,
    input  wire logic [ORDER_BITS-1:0]          filter_order,
    input  wire logic signed [COEF_BITS-1:0]    num_coef [MAX_ORDER+1],
    input  wire logic signed [COEF_BITS-1:0]    den_coef [MAX_ORDER],
    input  wire logic                           out_free,
    output logic                                idle,
    output logic                                done,
    output logic signed [SAMPLE_BITS-1:0]       y_out,
    output logic                                clip_out,
    output logic                                block_end_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_B,
        ST_ACC_B,
        ST_ROUND,
        ST_MUL_A,
        ST_ACC_A,
        ST_DONE
    } state_t;

    localparam logic signed [SUM_BITS-1:0] RND_HALF =
        SUM_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [SUM_BITS-1:0] Y_MAX =
        SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] Y_MIN =
        SUM_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    state_t                          state_reg;
    logic [ORDER_BITS-1:0]           stage_reg;
    logic signed [DELAY_BITS-1:0]    delay_reg [MAX_ORDER];
    logic signed [SAMPLE_BITS-1:0]   x_reg;
    logic signed [SAMPLE_BITS-1:0]   y_reg;
    logic                            clip_reg;
    logic                            be_reg;

    logic [ORDER_BITS-1:0]           ord;
    logic signed [COEF_BITS-1:0]     b_sel;
    logic signed [COEF_BITS-1:0]     a_sel;
    logic signed [DELAY_BITS-1:0]    d_sel;
    mac_ctrl_t                       mac_ctrl;
    logic signed [COEF_BITS-1:0]     mac_coef;
    logic signed [OPND_BITS-1:0]     mac_opnd;
    logic signed [DELAY_BITS-1:0]    mac_sum;
    logic signed [DELAY_BITS-1:0]    mac_acc;
    logic signed [SUM_BITS-1:0]      rnd_sum;
    logic signed [SUM_BITS-1:0]      rnd_int;
    logic signed [SAMPLE_BITS-1:0]   y_next;
    logic                            clip_next;

    // order in use, out-of-range codes folded into 1..MAX_ORDER
    always_comb begin
        if (filter_order == '0) begin
            ord = ORDER_BITS'(1);
        end else if (filter_order > MAX_ORDER) begin
            ord = ORDER_BITS'(MAX_ORDER);
        end else begin
            ord = filter_order;
        end
    end

    always_comb begin
        b_sel = num_coef[0];
        a_sel = den_coef[0];
        d_sel = '0;
        for (int k = 0; k <= MAX_ORDER; k++) begin
            if (stage_reg == ORDER_BITS'(k)) begin
                b_sel = num_coef[k];
            end
        end
        for (int k = 0; k < MAX_ORDER; k++) begin
            if (stage_reg == ORDER_BITS'(k + 1)) begin
                a_sel = den_coef[k];
            end
            if (stage_reg == ORDER_BITS'(k) && stage_reg < ord) begin
                d_sel = delay_reg[k];
            end
        end
    end

    always_comb begin
        mac_ctrl = '0;
        mac_coef = b_sel;
        mac_opnd = OPND_BITS'(x_reg);
        case (state_reg)
            ST_MUL_B: begin
                mac_ctrl.mul_en = 1'b1;
            end
            ST_ACC_B: begin
                mac_ctrl.acc_en   = 1'b1;
                mac_ctrl.use_base = 1'b1;
            end
            ST_MUL_A: begin
                mac_ctrl.mul_en = 1'b1;
                mac_coef        = a_sel;
                mac_opnd        = OPND_BITS'(y_reg);
            end
            ST_ACC_A: begin
                mac_ctrl.acc_en   = 1'b1;
                mac_ctrl.subtract = 1'b1;
            end
            default: begin
                mac_ctrl = '0;
            end
        endcase
    end

    iir_df2t_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .coef (mac_coef),
        .opnd (mac_opnd),
        .base (d_sel),
        .sum  (mac_sum),
        .acc  (mac_acc)
    );

    // round half up, then clamp to the sample range
    always_comb begin
        rnd_sum = SUM_BITS'(mac_acc) + RND_HALF;
        rnd_int = rnd_sum >>> COEF_FRAC_BITS;
        if (rnd_int > Y_MAX) begin
            y_next    = SAMPLE_BITS'(Y_MAX);
            clip_next = 1'b1;
        end else if (rnd_int < Y_MIN) begin
            y_next    = SAMPLE_BITS'(Y_MIN);
            clip_next = 1'b1;
        end else begin
            y_next    = SAMPLE_BITS'(rnd_int);
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            stage_reg <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            clip_reg  <= 1'b0;
            be_reg    <= 1'b0;
            for (int k = 0; k < MAX_ORDER; k++) begin
                delay_reg[k] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        x_reg     <= sample;
                        be_reg    <= block_end;
                        stage_reg <= '0;
                        state_reg <= ST_MUL_B;
                    end
                end
                ST_MUL_B: begin
                    state_reg <= ST_ACC_B;
                end
                ST_ACC_B: begin
                    if (stage_reg == '0) begin
                        state_reg <= ST_ROUND;
                    end else begin
                        state_reg <= ST_MUL_A;
                    end
                end
                ST_ROUND: begin
                    y_reg     <= y_next;
                    clip_reg  <= clip_next;
                    stage_reg <= ORDER_BITS'(1);
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_A: begin
                    state_reg <= ST_ACC_A;
                end
                ST_ACC_A: begin
                    for (int k = 0; k < MAX_ORDER; k++) begin
                        if (stage_reg == ORDER_BITS'(k + 1)) begin
                            delay_reg[k] <= mac_sum;
                        end
                    end
                    if (stage_reg == ord) begin
                        // stages past the order in use restart from zero
                        for (int k = 0; k < MAX_ORDER; k++) begin
                            if (ORDER_BITS'(k) >= ord) begin
                                delay_reg[k] <= '0;
                            end
                        end
                        state_reg <= ST_DONE;
                    end else begin
                        stage_reg <= stage_reg + ORDER_BITS'(1);
                        state_reg <= ST_MUL_B;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign idle          = (state_reg == ST_IDLE);
    assign done          = (state_reg == ST_DONE) && out_free;
    assign y_out         = y_reg;
    assign clip_out      = clip_reg;
    assign block_end_out = be_reg;

    `IIR_DF2T_ASSERT_IMP(a_stage_in_range,
        (state_reg != ST_IDLE && state_reg != ST_DONE), (stage_reg <= ord),
        "stage counter beyond filter order")
    `IIR_DF2T_ASSERT_NXT(a_last_stage_done,
        (state_reg == ST_ACC_A && stage_reg == ord), (state_reg == ST_DONE),
        "last stage did not finish the sample")
    `IIR_DF2T_ASSERT_NXT(a_start_busy, (idle && start), (!idle),
        "sequencer stayed idle after start")

endmodule

`default_nettype wire

/* tb/sv/iir_direct_form_2_transposed_test.sv */
// ----------------------------------------------------------------------------
// iir_direct_form_2_transposed_test
// self-checking bench for the direct form II transposed iir filter: a
// queue-fed driver offers samples, a monitor predicts each beat with a
// fixed-point copy of the filter and checks every result field, across
// several orders and coefficient sets under varying backpressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iir_direct_form_2_transposed_test import iir_df2t_pkg::*;;

    localparam int     FRAC_BITS      = 28;
    localparam longint SAMPLE_HI      = 64'sd8388607;
    localparam longint SAMPLE_LO      = -64'sd8388608;
    localparam longint DELAY_HI       = longint'(DELAY_MAX);
    localparam longint DELAY_LO       = longint'(DELAY_MIN);
    localparam longint HALF_LSB       = longint'(1) <<< (FRAC_BITS - 1);
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     LONG_HOLD      = 300;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic signed [23:0] sample;
        logic               blk_end;
    } sample_beat_t;

    typedef struct packed {
        logic signed [23:0] filtered;
        logic               blk_end;
        logic               clipped;
    } filt_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [COEF_BITS-1:0]   cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [23:0]     s_sample_in = '0;
    logic                   s_block_end = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [23:0]     m_filtered_out;
    logic                   m_block_end_out;
    logic                   m_clipped;

    sample_beat_t pending_q[$];
    filt_result_t expected_q[$];

    logic [1:0]  order_cfg;
    longint      b_coef[4];
    longint      a_coef[4];
    longint      delay_state[3];
    logic [31:0] set_b[4];
    logic [31:0] set_a[4];

    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    int   sink_hold_left = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    logic in_taken = 1'b0;

    iir_direct_form_2_transposed i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_in     (s_sample_in),
        .s_block_end     (s_block_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_filtered_out  (m_filtered_out),
        .m_block_end_out (m_block_end_out),
        .m_clipped       (m_clipped)
    );

    always #2 aclk = ~aclk;

    function automatic longint clamp_delay(input longint v);
        if (v > DELAY_HI) begin
            return DELAY_HI;
        end
        if (v < DELAY_LO) begin
            return DELAY_LO;
        end
        return v;
    endfunction

    function automatic filt_result_t filter_sample(input logic signed [23:0] x_in,
                                                   input logic be);
        longint       x;
        longint       acc;
        longint       y;
        longint       t;
        int           ord;
        int           k;
        filt_result_t r;
        x = longint'(x_in);
        ord = (order_cfg == 2'd0) ? 1 : int'(order_cfg);
        r.clipped = 1'b0;
        acc = clamp_delay(delay_state[0] + clamp_delay(b_coef[0] * x));
        y = (acc + HALF_LSB) >>> FRAC_BITS;
        if (y > SAMPLE_HI) begin
            y = SAMPLE_HI;
            r.clipped = 1'b1;
        end else if (y < SAMPLE_LO) begin
            y = SAMPLE_LO;
            r.clipped = 1'b1;
        end
        for (k = 0; k < ord - 1; k++) begin
            t = clamp_delay(delay_state[k + 1] + clamp_delay(b_coef[k + 1] * x));
            delay_state[k] = clamp_delay(t - clamp_delay(a_coef[k + 1] * y));
        end
        delay_state[ord - 1] = clamp_delay(clamp_delay(b_coef[ord] * x)
                                           - clamp_delay(a_coef[ord] * y));
        for (k = ord; k < 3; k++) begin
            delay_state[k] = 0;
        end
        r.filtered = y[23:0];
        r.blk_end = be;
        return r;
    endfunction

    function automatic logic signed [23:0] random_sample();
        case ($urandom_range(9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2, 3, 4: return 24'($urandom_range(511)) - 24'd256;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef(input bit narrow);
        if (narrow) begin
            return 32'($urandom_range(536870912)) - 32'd268435456;
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_ORDER) begin
            order_cfg = val[1:0];
        end else if (idx >= REG_DEN1) begin
            a_coef[idx - REG_DEN1 + 1] = longint'(signed'(val));
        end else begin
            b_coef[idx - REG_NUM0] = longint'(signed'(val));
        end
    endtask

    task automatic program_filter(input logic [1:0] ord);
        int k;
        write_reg(REG_ORDER, 32'(ord));
        for (k = 0; k < 4; k++) begin
            write_reg(REG_NUM0 + 3'(k), set_b[k]);
        end
        for (k = 1; k < 4; k++) begin
            write_reg(REG_DEN1 + 3'(k - 1), set_a[k]);
        end
    endtask

    task automatic set_idling(input idle_mode_t mode);
        src_idle_pct = (mode == IDLE_SRC) ? 65 : (mode == IDLE_BOTH) ? 32 : 0;
        sink_stall_pct = (mode == IDLE_SINK) ? 65 : (mode == IDLE_BOTH) ? 32 : 0;
    endtask

    task automatic push_sample(input logic signed [23:0] v, input logic be);
        pending_q.push_back('{sample: v, blk_end: be});
    endtask

    task automatic queue_samples(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            push_sample(random_sample(), $urandom_range(3) == 0);
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || expected_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // sample driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s_valid <= 1'b1;
                s_sample_in <= pending_q[0].sample;
                s_block_end <= pending_q[0].blk_end;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result sink, with an optional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (sink_hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
            if (sink_hold_left > 0) begin
                sink_hold_left--;
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        filt_result_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
            quiet_cycles = 0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                expected_q.push_back(filter_sample(s_sample_in, s_block_end));
                void'(pending_q.pop_front());
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with nothing pending",
                                              m_filtered_out));
                end else begin
                    want = expected_q.pop_front();
                    if (m_filtered_out !== want.filtered) begin
                        report_mismatch($sformatf("filtered_out got %0d want %0d",
                                                  m_filtered_out, want.filtered));
                    end
                    if (m_block_end_out !== want.blk_end) begin
                        report_mismatch($sformatf("block_end_out got %b want %b",
                                                  m_block_end_out, want.blk_end));
                    end
                    if (m_clipped !== want.clipped) begin
                        report_mismatch($sformatf("clipped got %b want %b",
                                                  m_clipped, want.clipped));
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int  ph;
        int  k;
        bit  narrow;
        logic [1:0] ord;
        order_cfg = 2'd1;
        for (k = 0; k < 4; k++) begin
            b_coef[k] = 0;
            a_coef[k] = 0;
        end
        b_coef[0] = 268435456;
        for (k = 0; k < 3; k++) begin
            delay_state[k] = 0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset coefficients pass the sample through
        push_sample(24'sd0, 1'b0);
        push_sample(24'sh7FFFFF, 1'b1);
        push_sample(24'sh800000, 1'b0);
        push_sample(24'sd1, 1'b1);
        push_sample(-24'sd1, 1'b0);
        wait_drained();

        // gain of one half: halves round up
        set_b = '{32'h0800_0000, 32'h0, 32'h0, 32'h0};
        set_a = '{32'h0, 32'h0, 32'h0, 32'h0};
        program_filter(2'd1);
        push_sample(24'sd1, 1'b0);
        push_sample(-24'sd1, 1'b1);
        push_sample(24'sd3, 1'b0);
        push_sample(-24'sd3, 1'b0);
        wait_drained();

        // extreme coefficients: clipping and delay line saturation
        set_b = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        set_a = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        program_filter(2'd3);
        push_sample(24'sh7FFFFF, 1'b0);
        push_sample(24'sh800000, 1'b1);
        push_sample(24'sh7FFFFF, 1'b0);
        push_sample(24'sd0, 1'b0);
        push_sample(24'sh800000, 1'b0);
        push_sample(24'sd0, 1'b1);
        push_sample(-24'sd1, 1'b0);
        push_sample(24'sh7FFFFF, 1'b1);
        wait_drained();

        for (ph = 0; ph < 8; ph++) begin
            narrow = !(ph == 2 || ph == 4 || ph == 5);
            for (k = 0; k < 4; k++) begin
                set_b[k] = rand_coef(narrow);
                set_a[k] = rand_coef(narrow);
            end
            case (ph)
                0: begin
                    ord = 2'd2;
                    set_b = '{32'd53687091, 32'd107374182, 32'd53687091, 32'd0};
                    set_a = '{32'd0, -32'sd161061274, 32'd53687091, 32'd0};
                end
                1: ord = 2'd3;
                2: ord = 2'd0;
                3: begin
                    ord = 2'd3;
                    set_b = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
                    set_a = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
                end
                4: ord = 2'd1;
                6: ord = 2'd2;
                default: ord = 2'd3;
            endcase
            program_filter(ord);
            set_idling(idle_mode_t'(ph % 4));
            queue_samples(80);
            if (ph == 0) begin
                @(posedge aclk);
                sink_hold_left = LONG_HOLD;
            end
            wait_drained();
            queue_samples(80);
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/iir_df2t_pkg.sv
design/iir_df2t_mac.sv
design/iir_df2t_seq.sv
design/iir_direct_form_2_transposed.sv
tb/sv/iir_direct_form_2_transposed_test.sv
